FILE: hdl/tvbb_pkg.sv
// Shared types, widths and constants for the transformed vertex bounding box.
package tvbb_pkg;

    localparam int NUM_AXES   = 3;
    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = NUM_AXES * COEF_W;
    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int FRAC_SHIFT = 12;
    localparam int ACC_W      = PROD_W + 3;
    localparam int Q_W        = ACC_W - FRAC_SHIFT;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = NUM_AXES * COORD_W;
    localparam int OUT_DATA_W = 2 * NUM_AXES * COORD_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ROW_W-1:0]          row_t;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

    // Identity rows: 1.0 in Q4.12 on the matching input axis
    localparam row_t ROW_X_RESET = row_t'(48'h0000_0000_1000);
    localparam row_t ROW_Y_RESET = row_t'(48'h0000_1000_0000);
    localparam row_t ROW_Z_RESET = row_t'(48'h1000_0000_0000);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam coord_t COORD_MAX = 32'sh7fff_ffff;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    // Load enables for the two transform pipeline stages
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } pipe_ctl_t;

endpackage

FILE: hdl/tvbb_xform.sv
// One output axis of the affine transform: products, then sum, round and saturate.
module tvbb_xform (
    input  logic               aclk,
    input  tvbb_pkg::pipe_ctl_t ctl,
    input  tvbb_pkg::row_t     row_coefs,
    input  tvbb_pkg::coord_t   shift,
    input  tvbb_pkg::coord_t   vtx_x,
    input  tvbb_pkg::coord_t   vtx_y,
    input  tvbb_pkg::coord_t   vtx_z,
    output tvbb_pkg::coord_t   result
);

    logic signed [tvbb_pkg::COEF_W-1:0] coef [tvbb_pkg::NUM_AXES];
    tvbb_pkg::coord_t                   vtx  [tvbb_pkg::NUM_AXES];
    logic signed [tvbb_pkg::PROD_W-1:0] prod_next [tvbb_pkg::NUM_AXES];
    logic signed [tvbb_pkg::PROD_W-1:0] prod_reg  [tvbb_pkg::NUM_AXES];
    logic signed [tvbb_pkg::ACC_W-1:0]  acc;
    logic signed [tvbb_pkg::Q_W-1:0]    quot;
    logic [tvbb_pkg::Q_W-tvbb_pkg::COORD_W:0] top_bits;
    tvbb_pkg::coord_t                   result_next;
    tvbb_pkg::coord_t                   result_reg;

    assign vtx[0] = vtx_x;
    assign vtx[1] = vtx_y;
    assign vtx[2] = vtx_z;

    always_comb begin
        for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
            coef[i]      = $signed(row_coefs[i*tvbb_pkg::COEF_W +: tvbb_pkg::COEF_W]);
            prod_next[i] = tvbb_pkg::PROD_W'(coef[i]) * tvbb_pkg::PROD_W'(vtx[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.prod_en) begin
            for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    // Exact sum in Q.28, round half up, floor by the fraction shift
    always_comb begin
        acc = tvbb_pkg::ACC_W'(prod_reg[0]) + tvbb_pkg::ACC_W'(prod_reg[1])
            + tvbb_pkg::ACC_W'(prod_reg[2])
            + (tvbb_pkg::ACC_W'(shift) <<< tvbb_pkg::FRAC_SHIFT)
            + tvbb_pkg::ROUND_HALF;
        quot     = $signed(acc[tvbb_pkg::ACC_W-1:tvbb_pkg::FRAC_SHIFT]);
        top_bits = quot[tvbb_pkg::Q_W-1:tvbb_pkg::COORD_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            result_next = quot[tvbb_pkg::COORD_W-1:0];
        end else if (quot[tvbb_pkg::Q_W-1]) begin
            result_next = tvbb_pkg::COORD_MIN;
        end else begin
            result_next = tvbb_pkg::COORD_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum_en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: hdl/transformed_vertex_bounding_box.sv
// Top level: affine transform of a vertex stream and running bounding box.
//
// Vertices (signed Q16.16) pass through a three-row affine transform with Q4.12
// coefficients and Q16.16 translations, rounded half up and saturated to 32 bits,
// and the per-axis minimum and maximum are tracked. tuser marks the first vertex
// of a box (the first vertex after reset also starts one); tlast emits the box
// including that vertex. One vertex is taken every cycle unless a blocked last vertex
// has filled the pipeline; a box reaches the output register after its last vertex
// passes the input register, the nine 16x32 multipliers, the sum with round and
// saturate, then the min/max update. Vertices that emit nothing keep flowing while
// a box waits on the output.
module transformed_vertex_bounding_box (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tvbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tvbb_pkg::ROW_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tvbb_pkg::IN_DATA_W-1:0]    s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic                              s_tuser,   // first_vertex
    input  logic                              s_tlast,   // last_vertex
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tvbb_pkg::OUT_DATA_W-1:0]   m_tdata    // low_x, low_y, low_z,
                                                         // high_x, high_y, high_z
);

    tvbb_pkg::row_t    row_reg   [tvbb_pkg::NUM_AXES];
    tvbb_pkg::coord_t  shift_reg [tvbb_pkg::NUM_AXES];

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic              s1_first_reg, s2_first_reg, s3_first_reg;
    logic              s1_last_reg,  s2_last_reg,  s3_last_reg;
    tvbb_pkg::coord_t  s1_vtx_reg [tvbb_pkg::NUM_AXES];

    logic              out_free, move3, s3_free, s2_free, en2, en3, accept;
    tvbb_pkg::pipe_ctl_t ctl;

    tvbb_pkg::coord_t  xf [tvbb_pkg::NUM_AXES];
    tvbb_pkg::coord_t  box_low_reg  [tvbb_pkg::NUM_AXES];
    tvbb_pkg::coord_t  box_high_reg [tvbb_pkg::NUM_AXES];
    tvbb_pkg::coord_t  box_low_next [tvbb_pkg::NUM_AXES];
    tvbb_pkg::coord_t  box_high_next[tvbb_pkg::NUM_AXES];
    logic              box_started_reg;
    tvbb_pkg::coord_t  out_low_reg  [tvbb_pkg::NUM_AXES];
    tvbb_pkg::coord_t  out_high_reg [tvbb_pkg::NUM_AXES];
    logic              m_valid_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= tvbb_pkg::ROW_X_RESET;
            row_reg[1] <= tvbb_pkg::ROW_Y_RESET;
            row_reg[2] <= tvbb_pkg::ROW_Z_RESET;
            for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
                shift_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tvbb_pkg::REG_ROW_X:   row_reg[0]   <= cfg_wdata;
                tvbb_pkg::REG_ROW_Y:   row_reg[1]   <= cfg_wdata;
                tvbb_pkg::REG_ROW_Z:   row_reg[2]   <= cfg_wdata;
                tvbb_pkg::REG_SHIFT_X: shift_reg[0] <= cfg_wdata[tvbb_pkg::COORD_W-1:0];
                tvbb_pkg::REG_SHIFT_Y: shift_reg[1] <= cfg_wdata[tvbb_pkg::COORD_W-1:0];
                tvbb_pkg::REG_SHIFT_Z: shift_reg[2] <= cfg_wdata[tvbb_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-stage flow control: a stage loads when it is empty or drains this cycle.
    // Only a last word needs room in the output register.
    assign out_free = !m_valid_reg || m_tready;
    assign move3    = s3_valid_reg && (!s3_last_reg || out_free);
    assign s3_free  = !s3_valid_reg || move3;
    assign en3      = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || en3;
    assign en2      = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || en2;
    assign accept   = s_tvalid && s_tready;

    assign ctl.prod_en = en2;
    assign ctl.sum_en  = en3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept || (s1_valid_reg && !en2);
            s2_valid_reg <= en2 || (s2_valid_reg && !en3);
            s3_valid_reg <= en3 || (s3_valid_reg && !move3);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_first_reg <= s_tuser;
            s1_last_reg  <= s_tlast;
            for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
                s1_vtx_reg[i] <= s_tdata[i*tvbb_pkg::COORD_W +: tvbb_pkg::COORD_W];
            end
        end
        if (en2) begin
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
        end
        if (en3) begin
            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    for (genvar a = 0; a < tvbb_pkg::NUM_AXES; a++) begin : g_axis
        tvbb_xform u_xform (
            .aclk      (aclk),
            .ctl       (ctl),
            .row_coefs (row_reg[a]),
            .shift     (shift_reg[a]),
            .vtx_x     (s1_vtx_reg[0]),
            .vtx_y     (s1_vtx_reg[1]),
            .vtx_z     (s1_vtx_reg[2]),
            .result    (xf[a])
        );
    end

    // Box update: restart on a first word or before any box exists
    always_comb begin
        for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
            if (s3_first_reg || !box_started_reg) begin
                box_low_next[i]  = xf[i];
                box_high_next[i] = xf[i];
            end else begin
                box_low_next[i]  = (xf[i] < box_low_reg[i])  ? xf[i] : box_low_reg[i];
                box_high_next[i] = (xf[i] > box_high_reg[i]) ? xf[i] : box_high_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_started_reg <= 1'b0;
            for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
                box_low_reg[i]  <= '0;
                box_high_reg[i] <= '0;
            end
        end else if (move3) begin
            box_started_reg <= 1'b1;
            for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
                box_low_reg[i]  <= box_low_next[i];
                box_high_reg[i] <= box_high_next[i];
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= (move3 && s3_last_reg) || (m_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (move3 && s3_last_reg) begin
            for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
                out_low_reg[i]  <= box_low_next[i];
                out_high_reg[i] <= box_high_next[i];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    always_comb begin
        for (int i = 0; i < tvbb_pkg::NUM_AXES; i++) begin
            m_tdata[i*tvbb_pkg::COORD_W +: tvbb_pkg::COORD_W] = out_low_reg[i];
            m_tdata[(i+tvbb_pkg::NUM_AXES)*tvbb_pkg::COORD_W +: tvbb_pkg::COORD_W] =
                out_high_reg[i];
        end
    end

    a_emit_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (move3 && s3_last_reg) |=> m_valid_reg)
        else $error("emitted box did not reach the output register");

    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        box_started_reg |-> (box_low_reg[0] <= box_high_reg[0]
            && box_low_reg[1] <= box_high_reg[1] && box_low_reg[2] <= box_high_reg[2]))
        else $error("box minimum exceeds maximum");

    a_stall_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s3_last_reg
            && m_valid_reg && !m_tready))
        else $error("input stalled without a blocked last word");

    a_stalled_last_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && s3_last_reg && !move3) |=> (s3_valid_reg && s3_last_reg))
        else $error("blocked last word dropped");

endmodule
